/* src/qn_pkg.sv */
// Shared constants and pipeline payload types for the quaternion normalize unit.
// Used by every module in src; depends on nothing.
package qn_pkg;
	localparam int FRAC_BITS = 14;
	localparam int QB = (FRAC_BITS + 1 < 15) ? FRAC_BITS + 1 : 15;
	localparam int W = 2 * FRAC_BITS + 38;
	localparam int NS = QB + 3;

	typedef struct packed {
		logic [W-1:0]  e;
		logic [W-1:0]  f;
		logic [W-1:0]  r;
		logic [QB-1:0] q;
	} lane_t;

	typedef struct packed {
		logic [W-1:0]    s;
		lane_t [3:0]     lane;
		logic [3:0]      neg;
		logic            zero;
	} item_t;
endpackage

/* src/qn_sumsq.sv */
// Front end: absolute values and squares, then the sum of squares and search setup.
// Depends on qn_pkg.
module qn_sumsq (
	input  logic                clk,
	input  logic                en1,
	input  logic                en2,
	input  logic [3:0][15:0]    comp,
	output qn_pkg::item_t       item_s2
);
	logic [3:0][31:0] sq_s1;
	logic [3:0]       neg_s1;
	logic [3:0][15:0] mag;
	logic [33:0]      sum;

	always_comb begin
		for (int i = 0; i < 4; i++) begin
			mag[i] = comp[i][15] ? 16'(-comp[i]) : comp[i];
		end
	end

	always_ff @(posedge clk) begin
		if (en1) begin
			for (int i = 0; i < 4; i++) begin
				sq_s1[i] <= 32'(mag[i]) * 32'(mag[i]);
				neg_s1[i] <= comp[i][15];
			end
		end
	end

	assign sum = 34'(sq_s1[0]) + 34'(sq_s1[1]) + 34'(sq_s1[2]) + 34'(sq_s1[3]);

	always_ff @(posedge clk) begin
		if (en2) begin
			item_s2.s <= qn_pkg::W'(sum);
			item_s2.neg <= neg_s1;
			item_s2.zero <= (sum == '0);
			for (int i = 0; i < 4; i++) begin
				item_s2.lane[i].e <= qn_pkg::W'(sum);
				item_s2.lane[i].f <= qn_pkg::W'(-qn_pkg::W'(sum));
				item_s2.lane[i].r <= qn_pkg::W'(sq_s1[i]) << (2 * qn_pkg::FRAC_BITS + 2);
				item_s2.lane[i].q <= '0;
			end
		end
	end
endmodule

/* src/qn_step.sv */
// One bit of the rounded-quotient search for all four components.
// Depends on qn_pkg.
module qn_step (
	input  logic            clk,
	input  logic            en,
	input  logic [4:0]      bit_idx,
	input  qn_pkg::item_t   d,
	output qn_pkg::item_t   q_o
);
	qn_pkg::item_t nx;
	logic [qn_pkg::W-1:0] cand [4];
	logic [6:0] sh1;
	logic [6:0] sh2;
	logic [6:0] sh4;

	// The candidate error term (2q-1)^2 * s is updated by shifts and adds only.
	always_comb begin
		nx = d;
		sh1 = 7'(bit_idx) + 7'd1;
		sh2 = 7'(bit_idx) + 7'd2;
		sh4 = 7'(bit_idx) + 7'(bit_idx) + 7'd2;
		for (int i = 0; i < 4; i++) begin
			cand[i] = d.lane[i].e + (d.lane[i].f << sh2) + (d.s << sh4);
			if (cand[i] <= d.lane[i].r) begin
				nx.lane[i].e = cand[i];
				nx.lane[i].f = d.lane[i].f + (d.s << sh1);
				nx.lane[i].q = d.lane[i].q | (qn_pkg::QB'(1) << bit_idx);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			q_o <= nx;
		end
	end
endmodule

/* src/quaternion_normalize_unit.sv */
// Top level of the quaternion normalize unit: stream ports, stall control, output stage.
// Depends on qn_pkg, qn_sumsq and qn_step.
//
// Takes one Q1.14 quaternion per transaction and returns it scaled to unit length,
// each component rounded to nearest with ties away from zero. An all-zero input
// returns zeros with the zero flag set. The pipeline accepts a transaction every
// cycle unless back pressure has filled it up to the input; it has one stage per
// quotient bit (15) plus square, sum and output stages. Back pressure stalls only
// the stages that are full.
module quaternion_normalize_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,   // q_scalar, q_x, q_y, q_z
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata,   // n_scalar, n_x, n_y, n_z
	output logic        m_tuser    // zero_magnitude
);
	localparam int NS = qn_pkg::NS;
	localparam int QB = qn_pkg::QB;

	logic [NS-1:0]    v_q;
	logic [NS:0]      en;
	qn_pkg::item_t    item [QB+1];
	logic [3:0][15:0] comp;
	logic [3:0][15:0] res;
	logic [63:0]      out_s3;
	logic             zero_s3;

	always_comb begin
		en[NS] = m_tready;
		for (int i = NS - 1; i >= 0; i--) begin
			en[i] = !v_q[i] || en[i+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else begin
			if (en[0]) begin
				v_q[0] <= s_tvalid;
			end
			for (int i = 1; i < NS; i++) begin
				if (en[i]) begin
					v_q[i] <= v_q[i-1];
				end
			end
		end
	end

	assign comp = s_tdata;
	assign s_tready = en[0];

	qn_sumsq u_sumsq (
		.clk     (clk),
		.en1     (en[0]),
		.en2     (en[1]),
		.comp    (comp),
		.item_s2 (item[0])
	);

	for (genvar j = 0; j < QB; j++) begin : g_step
		qn_step u_step (
			.clk     (clk),
			.en      (en[j+2]),
			.bit_idx (5'(QB - 1 - j)),
			.d       (item[j]),
			.q_o     (item[j+1])
		);
	end

	always_comb begin
		for (int i = 0; i < 4; i++) begin
			res[i] = item[QB].neg[i] ? 16'(-16'(item[QB].lane[i].q))
				: 16'(item[QB].lane[i].q);
			if (item[QB].zero) begin
				res[i] = '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en[NS-1]) begin
			out_s3 <= res;
			zero_s3 <= item[QB].zero;
		end
	end

	assign m_tvalid = v_q[NS-1];
	assign m_tdata = out_s3;
	assign m_tuser = zero_s3;

	a_zero_data: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tdata == 64'd0)
		else $error("zero flag with nonzero data");
	a_no_minfs: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[15:0] != 16'h8000 && m_tdata[31:16] != 16'h8000
			&& m_tdata[47:32] != 16'h8000 && m_tdata[63:48] != 16'h8000)
		else $error("component reached negative full scale");
	a_ready_free: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input stalled with empty output");
endmodule
